### rtl/u8u16_pkg.sv
// ----------------------------------------------------------------------------
// u8u16_pkg
// shared types, constants and the lead byte class function of the utf-8 to utf-16 unit
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // sequence lengths as decoded from a lead byte
  localparam logic [2:0] LEN_ONE   = 3'd1;
  localparam logic [2:0] LEN_TWO   = 3'd2;
  localparam logic [2:0] LEN_THREE = 3'd3;
  localparam logic [2:0] LEN_FOUR  = 3'd4;

  // payload bits kept from lead and trail bytes
  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'h07;
  localparam logic [7:0] TRAIL_MASK = 8'h3F;

  // surrogate arithmetic
  localparam logic [25:0] SUPP_BASE    = 26'h001_0000;
  localparam logic [15:0] HI_SURR_BASE = 16'hD800;
  localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
  localparam logic [7:0]  LEAD4_FIRST  = 8'hF0;

  localparam logic [15:0] CAP_RESET = 16'hFFFF;

  localparam int unsigned QUEUE_DEPTH = 4;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        end_of_string;
    logic [15:0] units_written;
    logic        overflowed;
  } result_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  // lead byte class
  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] len;
    len = LEN_ONE;
    if (b >= 8'hC2 && b <= 8'hDF) len = LEN_TWO;
    else if (b >= 8'hE0 && b <= 8'hEF) len = LEN_THREE;
    else if (b >= 8'hF0 && b <= 8'hF4) len = LEN_FOUR;
    return len;
  endfunction

endpackage

### rtl/utf8_to_utf16_transcoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit
// utf-8 byte stream in, utf-16 code units with per-string count out
// ----------------------------------------------------------------------------
// One byte is taken per cycle while in_stall is low. Each byte lands in an
// input register, is decoded in one pass against the open sequence state and
// leaves zero, one or two results in a four-entry output queue, whose entry
// registers make them visible. The output side gives one result per cycle
// while out_stall is low; a byte that closes a four-byte sequence leaves two
// results (a surrogate pair). While the queue has fewer than two free slots the
// input register keeps its byte, and the input stalls while it holds a kept byte.
// With the output never stalled the sustained rate is one byte per cycle for
// text without supplementary characters. out_capacity limits the units stored
// per string; it should only be written while no request is in flight.
module utf8_to_utf16_transcoder_unit import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] code_unit,
  output logic        unit_valid,
  output logic        end_of_string,
  output logic [15:0] units_written,
  output logic        overflowed
);

  push_t   push;
  result_t res0;
  result_t res1;
  result_t head;
  logic    room;

  // decode stage
  u8u16_decode u_decode (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .end_of_input   (end_of_input),
    .room           (room),
    .push           (push),
    .res0           (res0),
    .res1           (res1)
  );

  // result queue
  u8u16_out_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .res0      (res0),
    .res1      (res1),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (head)
  );

  assign code_unit     = head.code_unit;
  assign unit_valid    = head.unit_valid;
  assign end_of_string = head.end_of_string;
  assign units_written = head.units_written;
  assign overflowed    = head.overflowed;

endmodule

### rtl/u8u16_decode.sv
// ----------------------------------------------------------------------------
// u8u16_decode
// input register, sequence state and the single pass that turns one byte
// into at most two results
// ----------------------------------------------------------------------------
module u8u16_decode import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  input  logic        room,
  output push_t       push,
  output result_t     res0,
  output result_t     res1
);

  logic        item_valid;
  logic [7:0]  item_byte;
  logic        item_last;
  logic [15:0] out_capacity;
  logic [7:0]  pending_lead;
  logic [1:0]  bytes_remaining;
  logic [20:0] value_accumulator;
  logic [15:0] unit_counter;
  logic        overflow_flag;

  logic [7:0]  pending_lead_next;
  logic [1:0]  bytes_remaining_next;
  logic [20:0] value_accumulator_next;
  logic [15:0] unit_counter_next;
  logic        overflow_flag_next;

  logic        process;
  logic        accept;
  logic [2:0]  len;
  logic [1:0]  rem_dec;
  logic [20:0] acc_shift;
  logic [25:0] supp_off;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit;
  logic [15:0] unit_a;
  logic [15:0] unit_b;
  logic        cand_a;
  logic        cand_b;
  logic        ok_a;
  logic        ok_b;
  logic [15:0] cnt1;
  logic [15:0] cnt2;
  logic        ovf1;
  logic        ovf2;
  logic        only_one;

  // handshake of the input register
  assign process  = item_valid && room;
  assign in_stall = item_valid && !room;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (process) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_byte <= in_byte;
      item_last <= end_of_input;
    end
  end

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_capacity <= CAP_RESET;
    end else if (cfg_write_en) begin
      out_capacity <= cfg_write_data;
    end
  end

  // candidate units of this byte
  assign len       = seq_len(item_byte);
  assign rem_dec   = bytes_remaining - 2'd1;
  assign acc_shift = {value_accumulator[14:0], item_byte[5:0]};
  assign supp_off  = {5'd0, acc_shift} - SUPP_BASE;
  assign hi_unit   = supp_off[25:10] + HI_SURR_BASE;
  assign lo_unit   = {6'd0, acc_shift[9:0]} + LO_SURR_BASE;

  always_comb begin
    cand_a = 1'b0;
    cand_b = 1'b0;
    unit_a = {8'd0, item_byte};
    unit_b = lo_unit;
    if (bytes_remaining == 2'd0) begin
      cand_a = (len == LEN_ONE) || item_last;
    end else if (rem_dec == 2'd0) begin
      cand_a = 1'b1;
      if (pending_lead >= LEAD4_FIRST) begin
        unit_a = hi_unit;
        cand_b = 1'b1;
      end else begin
        unit_a = acc_shift[15:0];
      end
    end else if (item_last) begin
      cand_a = 1'b1;
      unit_a = {8'd0, pending_lead};
    end
  end

  // capacity check, one unit after the other
  assign ok_a = cand_a && (unit_counter < out_capacity);
  assign cnt1 = ok_a ? unit_counter + 16'd1 : unit_counter;
  assign ovf1 = overflow_flag || (cand_a && !ok_a);
  assign ok_b = cand_b && (cnt1 < out_capacity);
  assign cnt2 = ok_b ? cnt1 + 16'd1 : cnt1;
  assign ovf2 = ovf1 || (cand_b && !ok_b);

  // results as they enter the queue
  assign only_one = ok_a && !ok_b;

  always_comb begin
    push.first  = process && (ok_a || item_last);
    push.second = process && ok_b;
    if (ok_a) begin
      res0.code_unit     = unit_a;
      res0.unit_valid    = 1'b1;
      res0.end_of_string = item_last && only_one;
      res0.units_written = cnt1;
      res0.overflowed    = (item_last && only_one) ? ovf2 : overflow_flag;
    end else begin
      res0.code_unit     = 16'd0;
      res0.unit_valid    = 1'b0;
      res0.end_of_string = 1'b1;
      res0.units_written = cnt2;
      res0.overflowed    = ovf2;
    end
    res1.code_unit     = unit_b;
    res1.unit_valid    = 1'b1;
    res1.end_of_string = item_last;
    res1.units_written = cnt2;
    res1.overflowed    = item_last ? ovf2 : ovf1;
  end

  // next sequence state
  always_comb begin
    pending_lead_next      = pending_lead;
    bytes_remaining_next   = bytes_remaining;
    value_accumulator_next = value_accumulator;
    unit_counter_next      = cnt2;
    overflow_flag_next     = ovf2;
    if (item_last) begin
      pending_lead_next      = 8'd0;
      bytes_remaining_next   = 2'd0;
      value_accumulator_next = 21'd0;
      unit_counter_next      = 16'd0;
      overflow_flag_next     = 1'b0;
    end else if (bytes_remaining == 2'd0) begin
      if (len != LEN_ONE) begin
        pending_lead_next    = item_byte;
        bytes_remaining_next = 2'(len - 3'd1);
        case (len)
          LEN_TWO:   value_accumulator_next = {13'd0, item_byte & LEAD2_MASK};
          LEN_THREE: value_accumulator_next = {13'd0, item_byte & LEAD3_MASK};
          default:   value_accumulator_next = {13'd0, item_byte & LEAD4_MASK};
        endcase
      end
    end else begin
      bytes_remaining_next = rem_dec;
      if (rem_dec == 2'd0) begin
        value_accumulator_next = 21'd0;
        pending_lead_next      = 8'd0;
      end else begin
        value_accumulator_next = acc_shift;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_lead      <= 8'd0;
      bytes_remaining   <= 2'd0;
      value_accumulator <= 21'd0;
      unit_counter      <= 16'd0;
      overflow_flag     <= 1'b0;
    end else if (process) begin
      pending_lead      <= pending_lead_next;
      bytes_remaining   <= bytes_remaining_next;
      value_accumulator <= value_accumulator_next;
      unit_counter      <= unit_counter_next;
      overflow_flag     <= overflow_flag_next;
    end
  end

endmodule

### rtl/u8u16_out_queue.sv
// ----------------------------------------------------------------------------
// u8u16_out_queue
// four-entry result queue, takes up to two results a cycle, gives one while out_stall is low
// ----------------------------------------------------------------------------
module u8u16_out_queue import u8u16_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  input  result_t res0,
  input  result_t res1,
  output logic    room,
  output logic    out_valid,
  input  logic    out_stall,
  output result_t head
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t            entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   count_next;
  logic [PTR_W-1:0]   wr_ptr_next;
  logic               pop;
  logic [1:0]         push_count;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && !out_stall;
  assign room       = (count <= CNT_W'(QUEUE_DEPTH - 2));
  assign head       = entries[rd_ptr];
  assign push_count = {1'b0, push.first} + {1'b0, push.second};

  // occupancy
  always_comb begin
    count_next  = count + CNT_W'(push_count) - CNT_W'(pop);
    wr_ptr_next = wr_ptr + PTR_W'(push_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      count  <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push.first) begin
      entries[wr_ptr] <= res0;
    end
    if (push.second) begin
      entries[wr_ptr + PTR_W'(1)] <= res1;
    end
  end

endmodule

### rtl/u8u16_checker.sv
// ----------------------------------------------------------------------------
// u8u16_checker
// port-level checks of the transcoder, bound to the top level
// ----------------------------------------------------------------------------
module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] code_unit,
  input logic        unit_valid,
  input logic        end_of_string,
  input logic [15:0] units_written
);

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(code_unit) && $stable(units_written))
    else $error("stalled result changed");

  // nothing comes out right after reset
  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result right after reset");

  // an empty marker is always the end of its string and carries no unit
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !unit_valid |-> end_of_string && (code_unit == 16'd0))
    else $error("bad empty marker");

  // a delivered unit has been counted
  assert property (@(posedge clk) disable iff (rst)
    out_valid && unit_valid |-> (units_written != 16'd0))
    else $error("unit without count");

endmodule

bind utf8_to_utf16_transcoder_unit u8u16_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .code_unit     (code_unit),
  .unit_valid    (unit_valid),
  .end_of_string (end_of_string),
  .units_written (units_written)
);

### test/utf16_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf16_result_checker
// watches the byte and unit channels of the utf-8 to utf-16 unit, predicts the
// code units of every accepted byte and compares each accepted result with the
// oldest predicted one
// ----------------------------------------------------------------------------
module utf16_result_checker import u8u16_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write_en,
  input  logic [15:0] cfg_write_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        end_of_input,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] code_unit,
  input  logic        unit_valid,
  input  logic        end_of_string,
  input  logic [15:0] units_written,
  input  logic        overflowed,
  output int          mismatch_count,
  output int          units_outstanding
);

  // predicted results, oldest first
  result_t expected_units[$];

  // shadow of the decoder state and the capacity register
  logic [15:0] capacity;
  logic [7:0]  seq_lead;
  logic [1:0]  trail_left;
  logic [20:0] code_acc;
  logic [15:0] stored_count;
  logic        dropped;
  int          step_units;

  initial begin
    mismatch_count    = 0;
    units_outstanding = 0;
  end

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] mismatch in %s: got %h, expected %h", $time, field, got, want);
    mismatch_count++;
  endtask

  // lead byte class: length of the sequence it opens
  function automatic logic [2:0] lead_class(input logic [7:0] b);
    if (b >= 8'hC2 && b <= 8'hDF) return LEN_TWO;
    if (b >= 8'hE0 && b <= 8'hEF) return LEN_THREE;
    if (b >= 8'hF0 && b <= 8'hF4) return LEN_FOUR;
    return LEN_ONE;
  endfunction

  // store one unit if there is room, else flag the drop
  task automatic store_unit(input logic [15:0] unit);
    result_t r;
    if (stored_count < capacity) begin
      stored_count = stored_count + 16'd1;
      r.code_unit     = unit;
      r.unit_valid    = 1'b1;
      r.end_of_string = 1'b0;
      r.units_written = stored_count;
      r.overflowed    = dropped;
      expected_units.push_back(r);
      step_units++;
    end else begin
      dropped = 1'b1;
    end
  endtask

  // predict the results of one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic is_last);
    logic [2:0]  len;
    logic [7:0]  trail_bits;
    logic [31:0] offset;
    logic [15:0] hi_unit;
    logic [15:0] lo_unit;
    result_t     r;
    step_units = 0;
    if (trail_left == 2'd0) begin
      len = lead_class(b);
      if (len == LEN_ONE || is_last) begin
        store_unit({8'h00, b});
      end else begin
        seq_lead   = b;
        trail_left = len[1:0] - 2'd1;
        case (len)
          LEN_TWO:   code_acc = {13'd0, b & LEAD2_MASK};
          LEN_THREE: code_acc = {13'd0, b & LEAD3_MASK};
          default:   code_acc = {13'd0, b & LEAD4_MASK};
        endcase
      end
    end else begin
      trail_bits = b & TRAIL_MASK;
      code_acc   = {code_acc[14:0], trail_bits[5:0]};
      trail_left = trail_left - 2'd1;
      if (trail_left == 2'd0) begin
        if (seq_lead >= LEAD4_FIRST) begin
          // surrogate pair with wrapping arithmetic, halves judged one at a time
          offset  = {11'd0, code_acc} - {6'd0, SUPP_BASE};
          hi_unit = offset[25:10] + HI_SURR_BASE;
          lo_unit = {6'd0, code_acc[9:0]} + LO_SURR_BASE;
          store_unit(hi_unit);
          store_unit(lo_unit);
        end else begin
          store_unit(code_acc[15:0]);
        end
        code_acc = '0;
        seq_lead = '0;
      end else if (is_last) begin
        // string cut inside a sequence: raw lead byte only
        store_unit({8'h00, seq_lead});
      end
    end

    if (is_last) begin
      if (step_units == 0) begin
        r.code_unit     = 16'h0000;
        r.unit_valid    = 1'b0;
        r.end_of_string = 1'b1;
        r.units_written = stored_count;
        r.overflowed    = dropped;
      end else begin
        r = expected_units.pop_back();
        r.end_of_string = 1'b1;
        r.overflowed    = dropped;
      end
      expected_units.push_back(r);
      seq_lead     = '0;
      trail_left   = '0;
      code_acc     = '0;
      stored_count = '0;
      dropped      = 1'b0;
    end
  endtask

  // compare one accepted result with the oldest prediction
  task automatic check_result();
    result_t want;
    if (expected_units.size() == 0) begin
      report_mismatch("unexpected result", code_unit, 16'h0000);
    end else begin
      want = expected_units.pop_front();
      if (code_unit !== want.code_unit)
        report_mismatch("code_unit", code_unit, want.code_unit);
      if (unit_valid !== want.unit_valid)
        report_mismatch("unit_valid", {15'd0, unit_valid}, {15'd0, want.unit_valid});
      if (end_of_string !== want.end_of_string)
        report_mismatch("end_of_string", {15'd0, end_of_string},
                        {15'd0, want.end_of_string});
      if (units_written !== want.units_written)
        report_mismatch("units_written", units_written, want.units_written);
      if (overflowed !== want.overflowed)
        report_mismatch("overflowed", {15'd0, overflowed}, {15'd0, want.overflowed});
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      capacity     = CAP_RESET;
      seq_lead     = '0;
      trail_left   = '0;
      code_acc     = '0;
      stored_count = '0;
      dropped      = 1'b0;
      expected_units.delete();
    end else begin
      if (cfg_write_en)
        capacity = cfg_write_data;
      if (out_valid && !out_stall)
        check_result();
      if (in_valid && !in_stall)
        decode_byte(in_byte, end_of_input);
    end
    units_outstanding = expected_units.size();
  end

endmodule

### test/utf8_to_utf16_transcoder_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_unit_test
// drives directed and random utf-8 strings into the unit under several
// capacity settings, with bursty requests and a stalling receiver; the
// checker beside the unit predicts and compares every code unit
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_unit_test;
  import u8u16_pkg::*;

  typedef enum int {
    CH_ASCII,
    CH_TWO,
    CH_THREE,
    CH_FOUR,
    CH_NOISE,
    CH_CUT
  } char_kind_e;

  localparam int RANDOM_BYTES = 850;
  localparam int PHASE_BYTES  = 110;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 8;

  logic        clk            = 1'b0;
  logic        rst            = 1'b1;
  logic        cfg_write_en   = 1'b0;
  logic [15:0] cfg_write_data = 16'h0000;
  logic        in_valid       = 1'b0;
  logic [7:0]  in_byte        = 8'h00;
  logic        end_of_input   = 1'b0;
  logic        out_stall      = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        end_of_string;
  logic [15:0] units_written;
  logic        overflowed;

  int          mismatches;
  int          outstanding;
  logic [7:0]  text_bytes[$];
  int          burst_left;
  int          bytes_sent;
  bit          hold_go = 1'b0;

  utf8_to_utf16_transcoder_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .end_of_input   (end_of_input),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .code_unit      (code_unit),
    .unit_valid     (unit_valid),
    .end_of_string  (end_of_string),
    .units_written  (units_written),
    .overflowed     (overflowed)
  );

  utf16_result_checker u_checker (
    .clk               (clk),
    .rst               (rst),
    .cfg_write_en      (cfg_write_en),
    .cfg_write_data    (cfg_write_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .end_of_input      (end_of_input),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .code_unit         (code_unit),
    .unit_valid        (unit_valid),
    .end_of_string     (end_of_string),
    .units_written     (units_written),
    .overflowed        (overflowed),
    .mismatch_count    (mismatches),
    .units_outstanding (outstanding)
  );

  always #4 clk = ~clk;

  // run time guard
  initial begin : run_guard
    #2_000_000;
    $display("utf8_to_utf16_transcoder_unit test failed");
    $finish;
  end

  // one byte request, held until taken, then a gap at the end of a burst
  task automatic send_byte(input logic [7:0] b, input logic is_last);
    in_valid     = 1'b1;
    in_byte      = b;
    end_of_input = is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    bytes_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic send_text(input bit ends);
    foreach (text_bytes[i])
      send_byte(text_bytes[i], ends && (i == text_bytes.size() - 1));
  endtask

  // no request in flight and every predicted unit delivered
  task automatic wait_idle();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic [15:0] cap);
    wait_idle();
    cfg_write_en   = 1'b1;
    cfg_write_data = cap;
    @(negedge clk);
    cfg_write_en   = 1'b0;
  endtask

  // mostly a proper continuation byte, sometimes anything
  function automatic logic [7:0] trail_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'h80 | 8'($urandom_range(0, 63));
  endfunction

  // append one character, well formed or not, to the text
  task automatic add_char();
    int         pick;
    int         trails;
    char_kind_e kind;
    pick = $urandom_range(0, 99);
    if (pick < 30)      kind = CH_ASCII;
    else if (pick < 50) kind = CH_TWO;
    else if (pick < 65) kind = CH_THREE;
    else if (pick < 80) kind = CH_FOUR;
    else if (pick < 90) kind = CH_NOISE;
    else                kind = CH_CUT;
    case (kind)
      CH_ASCII: begin
        text_bytes.push_back(8'($urandom_range(0, 127)));
      end
      CH_TWO: begin
        text_bytes.push_back(8'($urandom_range(8'hC2, 8'hDF)));
        text_bytes.push_back(trail_byte());
      end
      CH_THREE: begin
        text_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        repeat (2) text_bytes.push_back(trail_byte());
      end
      CH_FOUR: begin
        text_bytes.push_back(8'($urandom_range(8'hF0, 8'hF4)));
        repeat (3) text_bytes.push_back(trail_byte());
      end
      CH_NOISE: begin
        text_bytes.push_back(8'($urandom_range(0, 255)));
      end
      default: begin
        // lead followed by too few continuation bytes
        trails = $urandom_range(0, 1);
        if ($urandom_range(0, 1) == 0) begin
          text_bytes.push_back(8'($urandom_range(8'hE0, 8'hEF)));
        end else begin
          text_bytes.push_back(8'($urandom_range(8'hF0, 8'hF4)));
          trails = trails + $urandom_range(0, 1);
        end
        repeat (trails) text_bytes.push_back(trail_byte());
      end
    endcase
  endtask

  task automatic build_string();
    text_bytes.delete();
    repeat ($urandom_range(1, 10)) add_char();
  endtask

  // receiver stall patterns, plus one long hold-off on request
  initial begin : receiver
    int mode;
    int left;
    int tick;
    mode = 0;
    left = 0;
    tick = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go   = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left <= 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(20, 200);
      end
      left--;
      tick++;
      case (mode)
        0:       out_stall = 1'b0;
        1:       out_stall = ($urandom_range(0, 3) == 0);
        2:       out_stall = ($urandom_range(0, 3) != 0);
        default: out_stall = ((tick % 5) < 2);
      endcase
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int          phase;
    int          phase_start;
    logic [15:0] cap;
    bit          ends;
    burst_left = $urandom_range(1, 40);
    bytes_sent = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ascii extremes and the longest two-byte value
    text_bytes = '{8'h00, 8'h7F, 8'hDF, 8'hBF};
    send_text(1'b1);
    // three-byte top, overlong four-byte that wraps, top of the plane range
    text_bytes = '{8'hEF, 8'hBF, 8'hBF, 8'hF0, 8'h80, 8'h80, 8'h80,
                   8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_text(1'b1);
    // stray continuation and non-lead bytes pass through
    text_bytes = '{8'h80, 8'hC1, 8'hF5, 8'hFF};
    send_text(1'b1);
    // string cut inside a sequence
    text_bytes = '{8'hE2, 8'h82};
    send_text(1'b1);
    // lead byte that ends the string
    text_bytes = '{8'hC3};
    send_text(1'b1);

    // no room at all: empty end marker
    write_capacity(16'h0000);
    text_bytes = '{8'h41};
    send_text(1'b1);
    // room for one half of a surrogate pair only
    write_capacity(16'h0001);
    text_bytes = '{8'hF0, 8'h90, 8'h80, 8'h80};
    send_text(1'b1);
    // capacity lowered while a string is open
    write_capacity(CAP_RESET);
    text_bytes = '{8'h41};
    send_text(1'b0);
    write_capacity(16'h0000);
    text_bytes = '{8'h42};
    send_text(1'b1);

    // random strings, one capacity setting per phase
    phase      = 0;
    bytes_sent = 0;
    while (bytes_sent < RANDOM_BYTES) begin
      case (phase % 6)
        0:       cap = 16'($urandom_range(0, 65535));
        1:       cap = CAP_RESET;
        2:       cap = 16'h0000;
        3:       cap = 16'($urandom_range(1, 3));
        4:       cap = 16'($urandom_range(4, 24));
        default: cap = 16'($urandom_range(25, 200));
      endcase
      write_capacity(cap);
      if (phase == 1) hold_go = 1'b1;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        build_string();
        // the last string of a phase is sometimes left open across the write
        ends = !((bytes_sent - phase_start + text_bytes.size() >= PHASE_BYTES) &&
                 ($urandom_range(0, 2) == 0));
        send_text(ends);
      end
      phase++;
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("utf8_to_utf16_transcoder_unit test passed");
    end else begin
      $display("utf8_to_utf16_transcoder_unit test failed");
    end
    $finish;
  end

endmodule

### sim.f
rtl/u8u16_pkg.sv
rtl/u8u16_decode.sv
rtl/u8u16_out_queue.sv
rtl/utf8_to_utf16_transcoder_unit.sv
rtl/u8u16_checker.sv
test/utf16_result_checker.sv
test/utf8_to_utf16_transcoder_unit_test.sv
